// ===== rtl/lte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lte_pkg: shared types and constants of the lux to exposure value converter
// Holds the low-light lookup table, the divide-by-five reciprocal and the
// record that moves from one squaring cell to the next.
// ----------------------------------------------------------------------------
package lte_pkg;

	// Fraction bits of both the lux input and the exposure value result.
	localparam int FRAC_BITS = 10;

	// Field widths.
	localparam int LUX_W = 30;
	localparam int EV_W  = 16;
	localparam int Q_W   = 29;	// floor(2*lux/5) stays below 2^29
	localparam int Z_W   = FRAC_BITS + 1;	// mantissa in [1,2)

	// Number of squaring cells, one per fraction bit of the result.
	localparam int NUM_CELLS = FRAC_BITS;

	// Exposure value returned for zero lux.
	localparam logic signed [EV_W-1:0] EV_ZERO = -16'sd5120;

	// Largest lux handled by the table: one half.
	localparam logic [LUX_W-1:0] HALF_LUX = 30'd512;

	// Multiply by this and drop DIV5_SHIFT bits to divide a 32-bit value by 5.
	localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;
	localparam int DIV5_SHIFT = 34;

	// Integer part of log2 when the leading one sits at the top of q.
	localparam logic signed [5:0] INT_TOP = 6'sd18;

	// Weight of the first fraction bit decided by the squaring chain.
	localparam logic [FRAC_BITS-1:0] WT_FIRST = 10'd512;

	// Table length and index width.
	localparam int TAB_LEN = 129;
	localparam int TAB_IW  = 8;

	// Exposure values for lux in steps of 4/1024.
	localparam logic signed [EV_W-1:0] EV_TAB [TAB_LEN] = '{
		-16'sd5120,
		-16'sd9546, -16'sd8522, -16'sd7923, -16'sd7498,
		-16'sd7168, -16'sd6899, -16'sd6671, -16'sd6474,
		-16'sd6300, -16'sd6144, -16'sd6003, -16'sd5875,
		-16'sd5756, -16'sd5647, -16'sd5545, -16'sd5450,
		-16'sd5360, -16'sd5276, -16'sd5196, -16'sd5120,
		-16'sd5048, -16'sd4979, -16'sd4914, -16'sd4851,
		-16'sd4790, -16'sd4732, -16'sd4677, -16'sd4623,
		-16'sd4571, -16'sd4521, -16'sd4473, -16'sd4426,
		-16'sd4380, -16'sd4336, -16'sd4293, -16'sd4252,
		-16'sd4211, -16'sd4172, -16'sd4133, -16'sd4096,
		-16'sd4060, -16'sd4024, -16'sd3989, -16'sd3955,
		-16'sd3922, -16'sd3890, -16'sd3858, -16'sd3827,
		-16'sd3796, -16'sd3766, -16'sd3737, -16'sd3708,
		-16'sd3680, -16'sd3653, -16'sd3626, -16'sd3599,
		-16'sd3573, -16'sd3547, -16'sd3522, -16'sd3497,
		-16'sd3473, -16'sd3449, -16'sd3425, -16'sd3402,
		-16'sd3379, -16'sd3356, -16'sd3334, -16'sd3312,
		-16'sd3291, -16'sd3269, -16'sd3248, -16'sd3228,
		-16'sd3207, -16'sd3187, -16'sd3167, -16'sd3148,
		-16'sd3128, -16'sd3109, -16'sd3091, -16'sd3072,
		-16'sd3054, -16'sd3036, -16'sd3018, -16'sd3000,
		-16'sd2982, -16'sd2965, -16'sd2948, -16'sd2931,
		-16'sd2915, -16'sd2898, -16'sd2882, -16'sd2866,
		-16'sd2850, -16'sd2834, -16'sd2818, -16'sd2803,
		-16'sd2787, -16'sd2772, -16'sd2757, -16'sd2742,
		-16'sd2728, -16'sd2713, -16'sd2699, -16'sd2684,
		-16'sd2670, -16'sd2656, -16'sd2642, -16'sd2629,
		-16'sd2615, -16'sd2602, -16'sd2588, -16'sd2575,
		-16'sd2562, -16'sd2549, -16'sd2536, -16'sd2523,
		-16'sd2510, -16'sd2498, -16'sd2485, -16'sd2473,
		-16'sd2461, -16'sd2449, -16'sd2437, -16'sd2425,
		-16'sd2413, -16'sd2401, -16'sd2389, -16'sd2378
	};

	// Output of the front stage.
	typedef struct packed {
		logic                   vld;
		logic                   byp;	// result already final (table path)
		logic signed [EV_W-1:0] ev;
		logic [Q_W-1:0]         q;	// floor(2*lux/5)
	} lte_front_t;

	// Record handed along the squaring chain.
	typedef struct packed {
		logic                   vld;
		logic                   byp;
		logic [Z_W-1:0]         z;
		logic signed [EV_W-1:0] y;
		logic [FRAC_BITS-1:0]   wt;
	} lte_stage_t;

endpackage
`default_nettype wire

// ===== rtl/lte_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lte_front: input stage of the converter
// Handles zero and low lux through the interpolated table, and forms
// floor(2*lux/5) for the logarithm path with one reciprocal multiply.
// ----------------------------------------------------------------------------
module lte_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          take,
	input  wire logic [lte_pkg::LUX_W-1:0]     lux,
	output lte_pkg::lte_front_t                fr_s1
);
	import lte_pkg::*;

	logic [6:0]               k;
	logic [1:0]               w;
	logic [TAB_IW-1:0]        kp1;
	logic signed [16:0]       lo17;
	logic signed [16:0]       up17;
	logic signed [16:0]       dif17;
	logic signed [18:0]       mul19;
	logic signed [16:0]       sm17;
	logic [30:0]              twice;
	logic [62:0]              prod;
	logic                     byp;
	logic signed [EV_W-1:0]   ev;

	// Table interpolation between entries k and k+1 with the extra bias.
	always_comb begin
		k     = lux[8:2];
		w     = lux[1:0];
		kp1   = {1'b0, k} + 8'd1;
		lo17  = 17'(EV_TAB[{1'b0, k}]);
		up17  = 17'(EV_TAB[kp1]) + $signed({12'd0, k[6:2]});
		dif17 = up17 - lo17;
		mul19 = 19'(dif17) * $signed({17'd0, w});
		sm17  = lo17 + 17'(mul19 >>> 2);
	end

	// Divide 2*lux by five through the reciprocal.
	always_comb begin
		twice = {lux, 1'b0};
		prod  = {32'd0, twice} * {31'd0, DIV5_RECIP};
	end

	// Pick the path that yields the final value here.
	always_comb begin
		byp = 1'b1;
		ev  = EV_ZERO;
		if (lux == '0) begin
			ev = EV_ZERO;
		end else if (lux == HALF_LUX) begin
			ev = EV_TAB[TAB_LEN-1];
		end else if (lux < HALF_LUX) begin
			ev = sm17[EV_W-1:0];
		end else begin
			byp = 1'b0;
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_s1 <= '0;
		end else begin
			fr_s1.vld <= take;
			if (take) begin
				fr_s1.byp <= byp;
				fr_s1.ev  <= ev;
				fr_s1.q   <= prod[DIV5_SHIFT+Q_W-1:DIV5_SHIFT];
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lte_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lte_norm: two-stage normalizer
// Shifts q left until its leading one reaches the top bit, counting the
// shift, and hands the mantissa in [1,2) and the integer part of log2 on.
// ----------------------------------------------------------------------------
module lte_norm (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  lte_pkg::lte_front_t       fr_s1,
	output logic                      vld_s2,
	output lte_pkg::lte_stage_t       st_s3
);
	import lte_pkg::*;

	logic                     byp_s2;
	logic signed [EV_W-1:0]   ev_s2;
	logic [Q_W-1:0]           a_s2;
	logic [1:0]               lzh_s2;

	logic                     c16, c8, c4, c2, c1;
	logic [Q_W-1:0]           a1, a2, a3, a4, a5;
	logic [4:0]               lz;
	logic signed [5:0]        ipart;

	// Coarse steps: shifts of 16 and 8.
	always_comb begin
		c16 = (fr_s1.q[28:13] == '0);
		a1  = c16 ? (fr_s1.q << 16) : fr_s1.q;
		c8  = (a1[28:21] == '0);
		a2  = c8 ? (a1 << 8) : a1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= fr_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (fr_s1.vld) begin
			byp_s2 <= fr_s1.byp;
			ev_s2  <= fr_s1.ev;
			a_s2   <= a2;
			lzh_s2 <= {c16, c8};
		end
	end

	// Fine steps: shifts of 4, 2 and 1, then the integer part.
	always_comb begin
		c4    = (a_s2[28:25] == '0);
		a3    = c4 ? (a_s2 << 4) : a_s2;
		c2    = (a3[28:27] == '0);
		a4    = c2 ? (a3 << 2) : a3;
		c1    = ~a4[28];
		a5    = c1 ? (a4 << 1) : a4;
		lz    = {lzh_s2, c4, c2, c1};
		ipart = INT_TOP - $signed({1'b0, lz});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s3 <= '0;
		end else begin
			st_s3.vld <= vld_s2;
			if (vld_s2) begin
				st_s3.byp <= byp_s2;
				st_s3.z   <= a5[Q_W-1:Q_W-Z_W];
				st_s3.y   <= byp_s2 ? ev_s2 : {ipart, {FRAC_BITS{1'b0}}};
				st_s3.wt  <= WT_FIRST;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lte_sq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lte_sq_cell: one squaring round of the binary logarithm
// Squares the mantissa; when the square reaches two it is halved and, unless
// the record bypasses, the current fraction weight is added to the result. Passes the record on.
// ----------------------------------------------------------------------------
module lte_sq_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  lte_pkg::lte_stage_t       st_in,
	output lte_pkg::lte_stage_t       st_q
);
	import lte_pkg::*;

	logic [2*Z_W-1:0]   sq;
	logic [Z_W:0]       t;
	logic               hi;

	// Square and rescale to FRAC_BITS fraction bits.
	always_comb begin
		sq = st_in.z * st_in.z;
		t  = sq[2*Z_W-1:FRAC_BITS];
		hi = t[Z_W];
	end

	// Valid flag and payload move to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q.vld <= st_in.vld;
			if (st_in.vld) begin
				st_q.byp <= st_in.byp;
				st_q.z   <= hi ? t[Z_W:1] : t[Z_W-1:0];
				st_q.y   <= (hi && !st_in.byp)
					? st_in.y + $signed({{(EV_W-FRAC_BITS){1'b0}}, st_in.wt})
					: st_in.y;
				st_q.wt  <= st_in.wt >> 1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lux_to_exposure_value_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lux_to_exposure_value_top: illuminance to exposure value converter
// Gives EV = log2(lux * 0.4) with 10 fraction bits from a lux reading with
// 10 fraction bits.
//
// Channel   Ports                        Transfer
// -------   --------------------------   ------------------------------
// input     start, busy, lux_fixed       rising edge with start & !busy
// result    done, ev_fixed               every cycle with done high
//
// Each item passes one front stage (table and divide by five), two
// normalizer stages and ten squaring cells; done is high while its result
// sits at the output of the last cell. busy stays high while an item is in
// the chain, including the cycle with done high, so a new item can start
// only after the previous result is taken; items never overlap.
// Reset clears all stage registers but the normalizer's first-stage payload; results cannot be held off.
// ----------------------------------------------------------------------------
module lux_to_exposure_value_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [29:0]         lux_fixed,
	output logic                     done,
	output logic signed [15:0]       ev_fixed
);
	import lte_pkg::*;

	lte_front_t              fr_s1;
	lte_stage_t              chain [NUM_CELLS+1];
	logic [NUM_CELLS:0]      cvld;
	logic                    norm_vld_s2;
	logic                    take;

	// Transfer of a new item.
	assign take = start & ~busy;

	lte_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.lux    (lux_fixed),
		.fr_s1  (fr_s1)
	);

	lte_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.fr_s1  (fr_s1),
		.vld_s2 (norm_vld_s2),
		.st_s3  (chain[0])
	);

	// Row of squaring cells, one per fraction bit.
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		lte_sq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.st_in  (chain[i]),
			.st_q   (chain[i+1])
		);
	end

	// Valid flags along the chain.
	always_comb begin
		for (int i = 0; i <= NUM_CELLS; i++) begin
			cvld[i] = chain[i].vld;
		end
	end

	// Busy while any stage holds an item.
	assign busy = fr_s1.vld | (|cvld) | norm_vld_s2;

	// Result from the last cell.
	assign done     = chain[NUM_CELLS].vld;
	assign ev_fixed = chain[NUM_CELLS].y;

endmodule
`default_nettype wire

// ===== rtl/lte_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lte_checker: port-level checks of the converter
// Watches the command and result ports for latency, ordering and range.
// ----------------------------------------------------------------------------
module lte_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire logic                done,
	input  wire logic signed [15:0]  ev_fixed
);

	// Each accepted item yields its result when it leaves the last squaring cell.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##13 done)
		else $error("result did not follow the accepted item on time");

	// Once an item is taken the block raises busy.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after a transfer");

	// A result only appears while an item is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result without an item in flight");

	// One item at a time, so results never come in back-to-back cycles.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// Exposure values stay between -10 and 20 (signed, 10 fraction bits).
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ev_fixed >= -16'sd10240) && (ev_fixed <= 16'sd20480))
		else $error("exposure value out of range");

endmodule

bind lux_to_exposure_value_top lte_checker u_lte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.ev_fixed (ev_fixed)
);
`default_nettype wire
